[rtl/fdp_pkg.sv]
// fdp_pkg: shared constants, types and codes for the fourier diagonal preconditioner
// used by every module of the block; no dependencies
package fdp_pkg;

   localparam int MAX_ROTORS = 8;
   localparam int MAX_CUTOFF = 127;

   localparam int ROT_CNT_W = 4;
   localparam int ROT_IDX_W = $clog2(MAX_ROTORS);
   localparam int CUTOFF_W  = 7;
   localparam int DIGIT_W   = 8;
   localparam int COUP_W    = 24;
   localparam int SHIFT_W   = 32;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam int MUL_W     = 24;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int SQ_W      = 2 * DIGIT_W;
   localparam int SUM_W     = 20;
   localparam int DEN_W     = PROD_W + SUM_W;
   localparam int QUO_W     = 48;
   localparam int CNT_W     = $clog2(QUO_W);
   localparam int NUM_SHIFT = 33;
   localparam int MAG_LO_W  = QUO_W - NUM_SHIFT;
   localparam int SHIFT_POS = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROTORS = 3'd0,
      CSR_CUTOFF = 3'd1,
      CSR_G      = 3'd2,
      CSR_J      = 3'd3,
      CSR_SHIFT  = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ADD,
      ST_GJ_MUL,
      ST_LO_MUL,
      ST_LO_ADD,
      ST_HI_MUL,
      ST_HI_ADD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_SQ,
      MUL_GJ,
      MUL_LO,
      MUL_HI
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        prod_en;
      logic        gj_en;
      logic        sum_add;
      logic        lo_add;
      logic        hi_add;
      logic        div_step;
      logic        finish;
      mul_sel_type mul_sel;
   } ctrl_type;

endpackage

[rtl/fdp_digits.sv]
// fdp_digits: mixed-radix element index, one digit per rotor, with wrap and last detect
// depends on fdp_pkg
module fdp_digits (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           advance,
   input  logic [fdp_pkg::ROT_CNT_W-1:0]  rotors,
   input  logic [fdp_pkg::DIGIT_W-1:0]    top_digit,
   input  logic [fdp_pkg::ROT_IDX_W-1:0]  rd_idx,
   output logic [fdp_pkg::DIGIT_W-1:0]    rd_digit,
   output logic                           last_elem
);
   import fdp_pkg::*;

   logic [DIGIT_W-1:0] digit_ff [MAX_ROTORS];
   logic [DIGIT_W-1:0] digit_in [MAX_ROTORS];
   logic               carry;
   logic               all_top;

   assign rd_digit  = digit_ff[rd_idx];
   assign last_elem = all_top;

   always_comb begin
      all_top = 1'b1;
      for (int j = 0; j < MAX_ROTORS; j++) begin
         if (j < int'(rotors) && digit_ff[j] != top_digit) begin
            all_top = 1'b0;
         end
      end
   end

   always_comb begin
      carry = 1'b1;
      for (int j = 0; j < MAX_ROTORS; j++) begin
         digit_in[j] = digit_ff[j];
         if (clear) begin
            digit_in[j] = '0;
         end else if (advance && carry && j < int'(rotors)) begin
            if (digit_ff[j] >= top_digit) begin
               digit_in[j] = '0;
            end else begin
               digit_in[j] = digit_ff[j] + DIGIT_W'(1);
               carry       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_ROTORS; j++) begin
            digit_ff[j] <= '0;
         end
      end else begin
         for (int j = 0; j < MAX_ROTORS; j++) begin
            digit_ff[j] <= digit_in[j];
         end
      end
   end

endmodule

[rtl/fdp_arith.sv]
// fdp_arith: shared 24x24 multiplier, sum and divisor accumulators, restoring divider
// depends on fdp_pkg
module fdp_arith (
   input  logic                           clock,
   input  fdp_pkg::ctrl_type              ctrl,
   input  logic [fdp_pkg::DATA_W-1:0]     sample,
   input  logic [fdp_pkg::DIGIT_W-1:0]    digit,
   input  logic [fdp_pkg::CUTOFF_W-1:0]   cutoff,
   input  logic [fdp_pkg::COUP_W-1:0]     coup_g,
   input  logic [fdp_pkg::COUP_W-1:0]     coup_j,
   input  logic [fdp_pkg::SHIFT_W-1:0]    shift_mag,
   output logic [fdp_pkg::DATA_W-1:0]     result,
   output logic                           sat
);
   import fdp_pkg::*;

   logic [DIGIT_W-1:0] fc_ext;
   logic [DIGIT_W-1:0] dabs;
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [PROD_W-1:0]  mul_out;
   logic [DATA_W-1:0]  mag;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  gj_ff, gj_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   dvd_ff, dvd_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic               neg_ff, neg_in;

   logic [DEN_W:0]     rem_sh;
   logic [DEN_W+1:0]   trial;
   logic               fits;

   assign fc_ext = DIGIT_W'(cutoff);
   assign dabs   = (digit >= fc_ext) ? (digit - fc_ext) : (fc_ext - digit);
   assign mag    = sample[DATA_W-1] ? (~sample + DATA_W'(1)) : sample;

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_SQ: begin
            mul_a = MUL_W'(dabs);
            mul_b = MUL_W'(dabs);
         end
         MUL_GJ: begin
            mul_a = coup_g;
            mul_b = coup_j;
         end
         MUL_LO: begin
            mul_a = gj_ff[MUL_W-1:0];
            mul_b = MUL_W'(sum_ff);
         end
         MUL_HI: begin
            mul_a = gj_ff[PROD_W-1:MUL_W];
            mul_b = MUL_W'(sum_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;

   assign rem_sh = {rem_ff, dvd_ff[QUO_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, den_ff};
   assign fits   = ~trial[DEN_W+1];

   always_comb begin
      prod_in = ctrl.prod_en ? mul_out : prod_ff;
      gj_in   = ctrl.gj_en ? mul_out : gj_ff;
      sum_in  = sum_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (ctrl.load) begin
         sum_in = '0;
         den_in = DEN_W'(shift_mag) << SHIFT_POS;
         rem_in = DEN_W'(mag >> MAG_LO_W);
         dvd_in = {mag[MAG_LO_W-1:0], (QUO_W - MAG_LO_W)'(0)};
         quo_in = '0;
         neg_in = sample[DATA_W-1];
      end
      if (ctrl.sum_add) begin
         sum_in = sum_ff + SUM_W'(prod_ff[SQ_W-1:0]);
      end
      if (ctrl.lo_add) begin
         den_in = den_ff + DEN_W'(prod_ff);
      end
      if (ctrl.hi_add) begin
         den_in = den_ff + (DEN_W'(prod_ff) << MUL_W);
      end
      if (ctrl.div_step) begin
         rem_in = fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      gj_ff   <= gj_in;
      sum_ff  <= sum_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         sat    = |quo_ff[QUO_W-1:DATA_W-1];
         result = sat ? {1'b0, {(DATA_W-1){1'b1}}} : quo_ff[DATA_W-1:0];
      end else begin
         sat    = quo_ff > {(QUO_W-DATA_W)'(0), 1'b1, (DATA_W-1)'(0)};
         result = sat ? {1'b1, (DATA_W-1)'(0)} : (~quo_ff[DATA_W-1:0] + DATA_W'(1));
      end
   end

endmodule

[rtl/fdp_seq.sv]
// fdp_seq: sequencer stepping the shared multiplier, accumulators and divider
// depends on fdp_pkg
module fdp_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_fire,
   input  logic                           out_free,
   input  logic [fdp_pkg::ROT_CNT_W-1:0]  rotors,
   output fdp_pkg::ctrl_type              ctrl,
   output logic [fdp_pkg::ROT_IDX_W-1:0]  rd_idx,
   output logic                           idle
);
   import fdp_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sq_last;
   logic             div_last;

   assign sq_last  = cnt_ff == (CNT_W'(rotors) - CNT_W'(1));
   assign div_last = cnt_ff == CNT_W'(QUO_W - 1);
   assign rd_idx   = cnt_ff[ROT_IDX_W-1:0];
   assign idle     = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire) state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: state_in = ST_SQ_ADD;
         ST_SQ_ADD: begin
            if (sq_last) begin
               cnt_in   = '0;
               state_in = ST_GJ_MUL;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_SQ_MUL;
            end
         end
         ST_GJ_MUL: state_in = ST_LO_MUL;
         ST_LO_MUL: state_in = ST_LO_ADD;
         ST_LO_ADD: state_in = ST_HI_MUL;
         ST_HI_MUL: state_in = ST_HI_ADD;
         ST_HI_ADD: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl         = '0;
      ctrl.mul_sel = MUL_SQ;
      unique case (state_ff)
         ST_IDLE:   ctrl.load = req_fire;
         ST_SQ_MUL: ctrl.prod_en = 1'b1;
         ST_SQ_ADD: ctrl.sum_add = 1'b1;
         ST_GJ_MUL: begin
            ctrl.gj_en   = 1'b1;
            ctrl.mul_sel = MUL_GJ;
         end
         ST_LO_MUL: begin
            ctrl.prod_en = 1'b1;
            ctrl.mul_sel = MUL_LO;
         end
         ST_LO_ADD: ctrl.lo_add = 1'b1;
         ST_HI_MUL: begin
            ctrl.prod_en = 1'b1;
            ctrl.mul_sel = MUL_HI;
         end
         ST_HI_ADD: ctrl.hi_add = 1'b1;
         ST_DIV:    ctrl.div_step = 1'b1;
         ST_DONE:   ctrl.finish = out_free;
         default:   ctrl.load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/fourier_diagonal_preconditioner.sv]
// fourier_diagonal_preconditioner: top level, csr file, result register
// depends on fdp_pkg, fdp_digits, fdp_arith, fdp_seq
//
//   channel   ports                                  direction
//   request   req_valid req_ready req_sample_value   in
//   result    rsp_valid rsp_ready rsp_scaled_value   out
//             rsp_saturated rsp_last_element
//   csr       csr_valid csr_ready csr_index csr_data in
//
// a request occupies the block until its result is registered: one multiply and one add
// per rotor digit on the shared 24x24 multiplier, the g*j multiply and the low and high
// multiply-adds forming the divisor, then 48 restoring divide steps on one 69-bit subtractor
// req_ready is high only while the sequencer is idle; a held result does not block it
// synchronous reset restores the register defaults and clears the element index
// a stalled result holds the sequencer in its last state until the result register frees
module fourier_diagonal_preconditioner (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [fdp_pkg::DATA_W-1:0] req_sample_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [fdp_pkg::DATA_W-1:0] rsp_scaled_value,
   output logic                             rsp_saturated,
   output logic                             rsp_last_element,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fdp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdp_pkg::SHIFT_W-1:0]      csr_data
);
   import fdp_pkg::*;

   logic [ROT_CNT_W-1:0] rot_ff, rot_in;
   logic [CUTOFF_W-1:0]  cut_ff, cut_in;
   logic [COUP_W-1:0]    g_ff, g_in;
   logic [COUP_W-1:0]    j_ff, j_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [ROT_CNT_W-1:0] eff_rot;
   logic [CUTOFF_W-1:0]  eff_cut;
   logic [COUP_W-1:0]    eff_g;
   logic [COUP_W-1:0]    eff_j;
   logic [SHIFT_W-1:0]   eff_shift;
   logic [DIGIT_W-1:0]   top_digit;

   logic                 csr_fire;
   logic                 geom_clear;
   logic                 req_fire;
   logic                 out_free;
   logic                 idle;
   ctrl_type             ctrl;
   logic [ROT_IDX_W-1:0] rd_idx;
   logic [DIGIT_W-1:0]   rd_digit;
   logic                 last_elem;
   logic [DATA_W-1:0]    result;
   logic                 sat;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = idle;
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rot_in     = rot_ff;
      cut_in     = cut_ff;
      g_in       = g_ff;
      j_in       = j_ff;
      shift_in   = shift_ff;
      geom_clear = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_ROTORS: begin
               rot_in     = csr_data[ROT_CNT_W-1:0];
               geom_clear = 1'b1;
            end
            CSR_CUTOFF: begin
               cut_in     = csr_data[CUTOFF_W-1:0];
               geom_clear = 1'b1;
            end
            CSR_G:     g_in     = csr_data[COUP_W-1:0];
            CSR_J:     j_in     = csr_data[COUP_W-1:0];
            CSR_SHIFT: shift_in = csr_data;
            default:   geom_clear = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (rot_ff < ROT_CNT_W'(2)) begin
         eff_rot = ROT_CNT_W'(2);
      end else if (rot_ff > ROT_CNT_W'(MAX_ROTORS)) begin
         eff_rot = ROT_CNT_W'(MAX_ROTORS);
      end else begin
         eff_rot = rot_ff;
      end
      if (cut_ff == '0) begin
         eff_cut = CUTOFF_W'(1);
      end else if (cut_ff > CUTOFF_W'(MAX_CUTOFF)) begin
         eff_cut = CUTOFF_W'(MAX_CUTOFF);
      end else begin
         eff_cut = cut_ff;
      end
      eff_g     = (g_ff == '0) ? COUP_W'(1) : g_ff;
      eff_j     = (j_ff == '0) ? COUP_W'(1) : j_ff;
      eff_shift = (shift_ff == '0) ? SHIFT_W'(1) : shift_ff;
      top_digit = {eff_cut, 1'b0};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result;
         rsp_sat_in   = sat;
         rsp_last_in  = last_elem;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff       <= ROT_CNT_W'(2);
         cut_ff       <= CUTOFF_W'(1);
         g_ff         <= COUP_W'(65536);
         j_ff         <= COUP_W'(65536);
         shift_ff     <= SHIFT_W'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         rot_ff       <= rot_in;
         cut_ff       <= cut_in;
         g_ff         <= g_in;
         j_ff         <= j_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last_element = rsp_last_ff;

   fdp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .rotors   (eff_rot),
      .ctrl     (ctrl),
      .rd_idx   (rd_idx),
      .idle     (idle)
   );

   fdp_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .clear     (geom_clear),
      .advance   (ctrl.finish),
      .rotors    (eff_rot),
      .top_digit (top_digit),
      .rd_idx    (rd_idx),
      .rd_digit  (rd_digit),
      .last_elem (last_elem)
   );

   fdp_arith u_arith (
      .clock     (clock),
      .ctrl      (ctrl),
      .sample    (req_sample_value),
      .digit     (rd_digit),
      .cutoff    (eff_cut),
      .coup_g    (eff_g),
      .coup_j    (eff_j),
      .shift_mag (eff_shift),
      .result    (result),
      .sat       (sat)
   );

endmodule

[rtl/fdp_checker.sv]
// fdp_checker: port-level assertions for the preconditioner, bound to the top level
// depends on fdp_pkg and fourier_diagonal_preconditioner
module fdp_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [fdp_pkg::DATA_W-1:0] req_sample_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [fdp_pkg::DATA_W-1:0] rsp_scaled_value,
   input  logic                              rsp_saturated,
   input  logic                              rsp_last_element,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [fdp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fdp_pkg::SHIFT_W-1:0]       csr_data
);
   import fdp_pkg::*;

   logic [DATA_W-1:0] pos_clip;
   logic [DATA_W-1:0] neg_clip;

   assign pos_clip = {1'b0, {(DATA_W-1){1'b1}}};
   assign neg_clip = {1'b1, (DATA_W-1)'(0)};

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a request is in progress");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_scaled_value == pos_clip || rsp_scaled_value == neg_clip))
      else $error("saturated flag with an unclipped value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_scaled_value) && $stable(rsp_last_element)))
      else $error("stalled result changed");

endmodule

bind fourier_diagonal_preconditioner fdp_checker u_fdp_checker (.*);

[tb/fourier_diagonal_preconditioner_tb.sv]
// fourier_diagonal_preconditioner_tb: self-checking testbench for the preconditioner,
// bursty request driver, stalling result monitor and csr phases checked against a predictor
// depends on fdp_pkg and fourier_diagonal_preconditioner
`timescale 1ns / 1ps

module fourier_diagonal_preconditioner_tb;
   import fdp_pkg::*;

   localparam int ITEM_TARGET  = 550;
   localparam int FIRST_PHASE  = 130;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 600;
   localparam int SETTLE       = 120;
   localparam int CYCLE_LIMIT  = 600000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic {ITEM_SAMPLE, ITEM_WRITE} item_kind_type;

   typedef struct packed {
      item_kind_type          kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [31:0]            data;
   } pending_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
      logic              last;
   } scaled_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [DATA_W-1:0]   req_sample_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]   rsp_scaled_value;
   logic                       rsp_saturated;
   logic                       rsp_last_element;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [SHIFT_W-1:0]         csr_data = '0;

   fourier_diagonal_preconditioner dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scaled_value(rsp_scaled_value),
      .rsp_saturated(rsp_saturated),
      .rsp_last_element(rsp_last_element),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [ROT_CNT_W-1:0] rotor_reg;
   logic [CUTOFF_W-1:0]  cutoff_reg;
   logic [COUP_W-1:0]    g_reg;
   logic [COUP_W-1:0]    j_reg;
   logic [SHIFT_W-1:0]   shift_reg;
   logic [DIGIT_W-1:0]   digit_reg [MAX_ROTORS];

   pending_type pending_q[$];
   scaled_type  scaled_q[$];

   int burst_left = 0;
   int gap_left = 0;
   int request_count = 0;
   int write_count = 0;
   int result_count = 0;
   int sat_count = 0;
   int last_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_hold = 0;
   logic hold_armed = 1'b1;
   logic [15:0] stall_pattern = '1;
   logic [5:0]  pattern_age = '0;

   function automatic void clear_digits();
      for (int k = 0; k < MAX_ROTORS; k++) digit_reg[k] = '0;
   endfunction

   function automatic void apply_write(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [SHIFT_W-1:0] data);
      case (idx)
         CSR_ROTORS: begin
            rotor_reg = data[ROT_CNT_W-1:0];
            clear_digits();
         end
         CSR_CUTOFF: begin
            cutoff_reg = data[CUTOFF_W-1:0];
            clear_digits();
         end
         CSR_G:     g_reg = data[COUP_W-1:0];
         CSR_J:     j_reg = data[COUP_W-1:0];
         CSR_SHIFT: shift_reg = data;
         default: ;
      endcase
   endfunction

   // divides one element by its diagonal entry and steps the index digits
   function automatic scaled_type precondition_next(input logic [DATA_W-1:0] x);
      scaled_type  r;
      int          rc, fc, top, d;
      logic [95:0] sq_sum, g_w, j_w, s_w, num, den, quo;
      logic [31:0] mag;
      logic        neg, carried;
      rc = (rotor_reg < 2) ? 2 : (rotor_reg > MAX_ROTORS) ? MAX_ROTORS : int'(rotor_reg);
      fc = (cutoff_reg == 0) ? 1 : (cutoff_reg > MAX_CUTOFF) ? MAX_CUTOFF : int'(cutoff_reg);
      top = 2 * fc;
      neg = x[31];
      mag = neg ? -x : x;
      sq_sum = '0;
      r.last = 1'b1;
      for (int k = 0; k < rc; k++) begin
         d = int'(digit_reg[k]) - fc;
         sq_sum = sq_sum + 96'(d * d);
         if (int'(digit_reg[k]) != top) r.last = 1'b0;
      end
      g_w = (g_reg == 0) ? 96'd1 : 96'(g_reg);
      j_w = (j_reg == 0) ? 96'd1 : 96'(j_reg);
      s_w = (shift_reg == 0) ? 96'd1 : 96'(shift_reg);
      den = g_w * j_w * sq_sum + (s_w << SHIFT_POS);
      num = 96'(mag) << 33;
      quo = num / den;
      r.sat = 1'b0;
      if (!neg) begin
         if (quo > 96'h7FFF_FFFF) begin
            r.value = 32'h7FFF_FFFF;
            r.sat = 1'b1;
         end else begin
            r.value = quo[31:0];
         end
      end else begin
         if (quo > 96'h8000_0000) begin
            r.value = 32'h8000_0000;
            r.sat = 1'b1;
         end else begin
            r.value = -quo[31:0];
         end
      end
      carried = 1'b1;
      for (int k = 0; k < rc && carried; k++) begin
         if (int'(digit_reg[k]) >= top) begin
            digit_reg[k] = '0;
         end else begin
            digit_reg[k] = digit_reg[k] + 1'b1;
            carried = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      pending_type p;
      p.kind = ITEM_WRITE;
      p.index = idx;
      p.data = data;
      pending_q.push_back(p);
   endfunction

   function automatic void add_sample(input logic [31:0] value);
      pending_type p;
      p.kind = ITEM_SAMPLE;
      p.index = '0;
      p.data = value;
      pending_q.push_back(p);
   endfunction

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
         1: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COUP_W-1:0] random_coupling();
      case ($urandom_range(0, 3))
         0: return 24'($urandom_range(1, 255));
         1: return 24'($urandom_range(32'h8000, 32'h1_8000));
         2: return 24'($urandom);
         default: return $urandom_range(0, 1) ? 24'h0 : 24'hFF_FFFF;
      endcase
   endfunction

   function automatic logic [SHIFT_W-1:0] random_shift();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(1, 255));
         1: return 32'($urandom_range(32'h8000, 32'h4_0000));
         2: return $urandom;
         default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
   endfunction

   // random register subset, garbage above each field narrower than 32 bits, then a run of elements
   function automatic void add_random_phase(input int count);
      logic [3:0] rotors;
      logic [6:0] cutoff;
      logic       wrote;
      wrote = 1'b0;
      if ($urandom_range(0, 1)) begin
         rotors = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(2, 3));
         add_write(CSR_ROTORS, {28'($urandom), rotors});
         wrote = 1'b1;
      end
      if ($urandom_range(0, 1)) begin
         cutoff = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 2));
         add_write(CSR_CUTOFF, {25'($urandom), cutoff});
         wrote = 1'b1;
      end
      if ($urandom_range(0, 1)) begin
         add_write(CSR_J, {8'($urandom), random_coupling()});
         wrote = 1'b1;
      end
      if ($urandom_range(0, 1)) begin
         add_write(CSR_SHIFT, random_shift());
         wrote = 1'b1;
      end
      if ($urandom_range(0, 3) == 0)
         add_write(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom);
      if (!wrote || $urandom_range(0, 1))
         add_write(CSR_G, {8'($urandom), random_coupling()});
      for (int k = 0; k < count; k++) add_sample(random_sample());
   endfunction

   // request driver: bursts with random gaps, csr writes only when the block has drained
   always @(posedge clock) begin : drive_proc
      pending_type head;
      logic        req_busy, csr_busy, next_req, next_csr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            scaled_q.push_back(precondition_next(req_sample_value));
            request_count++;
         end
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
            write_count++;
         end
         req_busy = req_valid && !req_ready;
         csr_busy = csr_valid && !csr_ready;
         next_req = req_busy;
         next_csr = csr_busy;
         if (!req_busy && !csr_busy && pending_q.size() != 0) begin
            head = pending_q[0];
            if (head.kind == ITEM_WRITE) begin
               if (scaled_q.size() == 0 && !(rsp_valid && rsp_ready)) begin
                  csr_index <= head.index;
                  csr_data <= head.data;
                  next_csr = 1'b1;
                  void'(pending_q.pop_front());
               end
            end else if (gap_left != 0) begin
               gap_left--;
            end else begin
               req_sample_value <= head.data;
               next_req = 1'b1;
               void'(pending_q.pop_front());
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 4))
                     0: gap_left = 0;
                     1, 2: gap_left = $urandom_range(1, 4);
                     3: gap_left = $urandom_range(5, 20);
                     default: gap_left = $urandom_range(20, 90);
                  endcase
               end else begin
                  burst_left--;
               end
            end
         end
         req_valid <= next_req;
         csr_valid <= next_csr;
      end
   end

   // one long receiver hold-off once traffic is flowing
   always @(posedge clock) begin
      if (reset) begin
         stall_hold <= 0;
      end else if (hold_armed && result_count >= HOLD_AFTER) begin
         stall_hold <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end
   end

   // receiver stall pattern, a rotating 16-bit mask reshuffled whenever the 6-bit age counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_age == 6'd63) begin
            case ($urandom_range(0, 2))
               0: stall_pattern <= '1;
               1: stall_pattern <= 16'($urandom);
               default: stall_pattern <= 16'($urandom) | 16'($urandom);
            endcase
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
         end
         pattern_age <= pattern_age + 1'b1;
         rsp_ready <= (stall_hold == 0) && stall_pattern[0];
      end
   end

   // result monitor
   always @(posedge clock) begin : check_proc
      scaled_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count <= result_count + 1;
         if (scaled_q.size() == 0) begin
            $display("%0t: unexpected result value=%h sat=%b last=%b", $time,
                     rsp_scaled_value, rsp_saturated, rsp_last_element);
            mismatch_count++;
         end else begin
            want = scaled_q.pop_front();
            if (rsp_scaled_value !== want.value) begin
               $display("%0t: scaled_value expected %h actual %h", $time, want.value,
                        rsp_scaled_value);
               mismatch_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, want.sat,
                        rsp_saturated);
               mismatch_count++;
            end
            if (rsp_last_element !== want.last) begin
               $display("%0t: last_element expected %b actual %b", $time, want.last,
                        rsp_last_element);
               mismatch_count++;
            end
            if (want.sat) sat_count++;
            if (want.last) last_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d requests still expected", $time, scaled_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int queued;
      rotor_reg = 4'd2;
      cutoff_reg = 7'd1;
      g_reg = 24'h01_0000;
      j_reg = 24'h01_0000;
      shift_reg = 32'h0001_0000;
      clear_digits();

      // default geometry: one full nine-element vector plus a wrap
      add_sample(32'h0);
      add_sample(32'h1);
      add_sample(32'hFFFF_FFFF);
      add_sample(32'h7FFF_FFFF);
      add_sample(32'h8000_0000);
      add_sample(32'h0001_0000);
      add_sample(32'hFFFF_0000);
      add_sample(32'h1234_5678);
      add_sample(32'h8765_4321);
      add_sample(32'h0002_0000);

      // same-value geometry rewrite, zero couplings and shift, masked cutoff bits
      add_write(CSR_ROTORS, 32'd2);
      add_write(CSR_CUTOFF, 32'hFFFF_FF81);
      add_write(CSR_G, 32'h0);
      add_write(CSR_J, 32'h0);
      add_write(CSR_SHIFT, 32'h0);
      add_sample(32'h7FFF_FFFF);
      add_sample(32'h8000_0000);
      add_sample(32'hFFFF_FFFF);
      add_sample(32'h1);
      add_sample(32'h0);

      // spare indexes, zero geometry, largest couplings and shift
      for (int k = CSR_SPARE_LO; k <= CSR_SPARE_HI; k++) add_write(3'(k), $urandom);
      add_write(CSR_ROTORS, 32'h0);
      add_write(CSR_CUTOFF, 32'h0);
      add_write(CSR_G, 32'h00FF_FFFF);
      add_write(CSR_J, 32'hFFFF_FFFF);
      add_write(CSR_SHIFT, 32'hFFFF_FFFF);
      add_sample(32'h7FFF_FFFF);
      add_sample(32'h8000_0000);
      add_sample(32'h0000_8000);
      add_sample(32'hC000_0000);

      // widest geometry
      add_write(CSR_ROTORS, 32'hF);
      add_write(CSR_CUTOFF, 32'd127);
      add_sample(32'h7FFF_FFFF);
      add_sample(32'h8000_0000);
      add_sample(32'h0100_0000);

      queued = 22;
      add_random_phase(FIRST_PHASE);
      queued += FIRST_PHASE;
      while (queued < ITEM_TARGET) begin
         int n;
         n = $urandom_range(10, 50);
         add_random_phase(n);
         queued += n;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || csr_valid || scaled_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d elements over %0d register writes in %0d cycles",
               request_count, write_count, cycle_count);
      $display("results checked %0d, clipped %0d, vector ends %0d, errors %0d",
               result_count, sat_count, last_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
rtl/fdp_pkg.sv
rtl/fdp_digits.sv
rtl/fdp_arith.sv
rtl/fdp_seq.sv
rtl/fourier_diagonal_preconditioner.sv
rtl/fdp_checker.sv
tb/fourier_diagonal_preconditioner_tb.sv
